/* design/tlcf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlcf_pkg
// Shared types and constants of the terminal log cleanup filter.
// ----------------------------------------------------------------------------
package tlcf_pkg;

	localparam int LINE_LIMIT  = 63;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int FILL_W      = $clog2(LINE_LIMIT + 1);
	localparam int LEN_W       = $clog2(LINE_LIMIT + 2);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SO  = 8'h0E;
	localparam logic [7:0] CH_SI  = 8'h0F;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_LBR = 8'h5B; // '['
	localparam logic [7:0] CH_Y   = 8'h59; // 'Y'
	localparam logic [7:0] CH_EXC = 8'h21; // '!'
	localparam logic [7:0] CH_LP  = 8'h28; // '('
	localparam logic [7:0] CH_RP  = 8'h29; // ')'
	localparam logic [7:0] CH_HSH = 8'h23; // '#'

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_ESC     = 3'd1,
		MODE_BRACKET = 3'd2,
		MODE_SKIP2   = 3'd3,
		MODE_SKIP1   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_BS    = 2'd1,
		ACT_STORE = 2'd2,
		ACT_NL    = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_CRCHK = 2'd1,
		ST_EMIT  = 2'd2
	} state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_line;
	} out_item_t;

endpackage
`default_nettype wire

/* design/tlcf_line_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlcf_line_ram
// Line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tlcf_line_ram
	import tlcf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [7:0]        wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [7:0]        rdata
);

	logic [7:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* design/tlcf_esc_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlcf_esc_parser
// Escape-sequence mode register and byte classification.
// ----------------------------------------------------------------------------
module tlcf_esc_parser
	import tlcf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] data_byte,
	input  wire logic       file_start,
	output act_t            act
);

	mode_t mode_q;
	mode_t mode_cur;
	mode_t mode_d;

	always_comb begin
		mode_cur = file_start ? MODE_NORMAL : mode_q;
		act      = ACT_NONE;
		mode_d   = MODE_NORMAL;
		case (mode_cur)
			MODE_ESC: begin
				if (data_byte == CH_LBR) begin
					mode_d = MODE_BRACKET;
				end else if (data_byte == CH_Y) begin
					mode_d = MODE_SKIP2;
				end else if (data_byte inside {CH_EXC, CH_LP, CH_RP, CH_HSH}) begin
					mode_d = MODE_SKIP1;
				end
			end
			MODE_BRACKET: begin
				if (!(data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]})) begin
					mode_d = MODE_BRACKET;
				end
			end
			MODE_SKIP2: mode_d = MODE_SKIP1;
			MODE_SKIP1: mode_d = MODE_NORMAL;
			default: begin
				case (data_byte)
					CH_BS:                          act = ACT_BS;
					CH_NUL, CH_BEL, CH_SO, CH_SI:   act = ACT_NONE;
					CH_ESC:                         mode_d = MODE_ESC;
					CH_LF:                          act = ACT_NL;
					default:                        act = ACT_STORE;
				endcase
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
		end else if (take) begin
			mode_q <= mode_d;
		end
	end

endmodule
`default_nettype wire

/* design/terminal_log_cleanup_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_log_cleanup_filter
// Cleans a terminal log stream and hands out lines, cut at 64 bytes, as runs.
// ----------------------------------------------------------------------------
// channel | signals                               | payload
// byte    | byte_valid / byte_ready / byte_data   | data_byte, file_start
// line    | line_valid / line_ready / line_data   | out_byte, last_of_line
//
// A byte that does not end a line is taken in the idle state. A newline
// after stored bytes goes through a carriage-return check state that reads
// the byte before it from the line RAM; a newline on an empty line skips it.
// A run of N bytes is then read out of the RAM at one byte per cycle while
// the output register can take it; no new byte is taken during the read-out.
// The output register lets the next byte in while the last result waits.
// Reset clears mode, fill count and control; the line RAM is not cleared.
// ----------------------------------------------------------------------------
module terminal_log_cleanup_filter
	import tlcf_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	output logic           byte_ready,
	input  wire in_item_t  byte_data,
	output logic           line_valid,
	input  wire logic      line_ready,
	output out_item_t      line_data
);

	state_t state_q, state_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [FILL_W-1:0] nl_pos_q, nl_pos_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LEN_W-1:0]  idx_q, idx_d;
	logic              pend_s1, pend_d;
	logic              last_s1, last_d;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              take;
	act_t              act;
	logic [FILL_W-1:0] pos;
	logic [FILL_W-1:0] nl_at;
	logic              issue;
	logic              load;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [7:0]        wdata, rdata;

	assign take = byte_valid && byte_ready;
	assign pos  = byte_data.file_start ? '0 : fill_q;

	tlcf_esc_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (byte_data.data_byte),
		.file_start (byte_data.file_start),
		.act        (act)
	);

	tlcf_line_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign load  = pend_s1 && (!out_valid_q || line_ready);
	assign issue = (state_q == ST_EMIT) && (idx_q != len_q) && (!pend_s1 || load);
	// carriage return just before the newline is overwritten
	assign nl_at = (rdata == CH_CR) ? nl_pos_q - 1'b1 : nl_pos_q;

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		nl_pos_d   = nl_pos_q;
		len_d      = len_q;
		idx_d      = idx_q;
		byte_ready = (state_q == ST_IDLE);
		we         = 1'b0;
		waddr      = ADDR_W'(pos);
		wdata      = byte_data.data_byte;
		re         = 1'b0;
		raddr      = ADDR_W'(idx_q);
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					fill_d = pos;
					case (act)
						ACT_BS: begin
							fill_d = (pos != '0) ? pos - 1'b1 : '0;
						end
						ACT_STORE: begin
							we = 1'b1;
							if (pos >= FILL_W'(LINE_LIMIT)) begin
								len_d   = LEN_W'(pos) + 1'b1;
								idx_d   = '0;
								fill_d  = '0;
								state_d = ST_EMIT;
							end else begin
								fill_d = pos + 1'b1;
							end
						end
						ACT_NL: begin
							fill_d = '0;
							if (pos == '0) begin
								we      = 1'b1;
								len_d   = LEN_W'(1);
								idx_d   = '0;
								state_d = ST_EMIT;
							end else begin
								re       = 1'b1;
								raddr    = ADDR_W'(pos - 1'b1);
								nl_pos_d = pos;
								state_d  = ST_CRCHK;
							end
						end
						default: ;
					endcase
				end
			end
			ST_CRCHK: begin
				we      = 1'b1;
				waddr   = ADDR_W'(nl_at);
				wdata   = CH_LF;
				len_d   = LEN_W'(nl_at) + 1'b1;
				idx_d   = '0;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				re = issue;
				if (issue) begin
					idx_d = idx_q + 1'b1;
				end
				if (load && last_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pend_d = pend_s1;
		last_d = last_s1;
		if (issue) begin
			pend_d = 1'b1;
			last_d = (idx_q + 1'b1 == len_q);
		end else if (load) begin
			pend_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			pend_s1     <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			len_q       <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			pend_s1 <= pend_d;
			last_s1 <= last_d;
			idx_q   <= idx_d;
			len_q   <= len_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (line_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		nl_pos_q <= nl_pos_d;
		if (load) begin
			out_q.out_byte     <= rdata;
			out_q.last_of_line <= last_s1;
		end
	end

	assign line_valid = out_valid_q;
	assign line_data  = out_q;

`ifndef ASSERT_OFF
	a_pend_only_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> state_q == ST_EMIT)
		else $error("read data pending outside of line read-out");

	a_crchk_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CRCHK |=> state_q == ST_EMIT)
		else $error("carriage-return check did not go to read-out");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> idx_q <= len_q && len_q != '0)
		else $error("read-out index beyond run length");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_LIMIT))
		else $error("fill count beyond line limit");
`endif

endmodule
`default_nettype wire
